### hw/rtl/b64sc_pkg.sv
// b64sc_pkg: types, constants and character mapping functions for the
// base64url stream codec. Depends on nothing; used by every rtl file.
package b64sc_pkg;

   // queue between front and back
   localparam int QUEUE_DEPTH = 4;

   // configuration port
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIRECTION = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ALPHABET  = 2'd1;

   // direction codes
   localparam logic DIR_ENCODE = 1'b0;
   localparam logic DIR_DECODE = 1'b1;

   // ascii codes
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_DASH    = 8'h2d;
   localparam logic [7:0] CHAR_USCORE  = 8'h5f;

   // input word
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   // result word
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
      logic       no_byte;
      logic       input_stopped;
   } rsp_type;

   // one group of results queued by the front for the back
   typedef struct packed {
      logic [3:0][7:0] data;
      logic [1:0]      cnt_m1;
      logic            last;
      logic            stop;
      logic            nob;
   } job_type;

   // sextet to character
   function automatic logic [7:0] enc_char(input logic [5:0] s, input logic alt);
      logic [7:0] s8;
      logic [7:0] r;
      s8 = {2'b00, s};
      if (!alt) begin
         if (s8 < 8'd26)      r = CHAR_UPPER_A + s8;
         else if (s8 < 8'd52) r = CHAR_LOWER_A + s8 - 8'd26;
         else if (s8 < 8'd62) r = CHAR_ZERO + s8 - 8'd52;
         else if (s8 == 8'd62) r = CHAR_DASH;
         else                 r = CHAR_USCORE;
      end else begin
         if (s8 < 8'd26)      r = CHAR_LOWER_A + s8;
         else if (s8 < 8'd36) r = CHAR_ZERO + s8 - 8'd26;
         else if (s8 == 8'd36) r = CHAR_DASH;
         else if (s8 == 8'd37) r = CHAR_USCORE;
         else                 r = CHAR_UPPER_A + s8 - 8'd38;
      end
      return r;
   endfunction

   // letters, digits, dash and underscore
   function automatic logic is_url_char(input logic [7:0] c);
      return (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) ||
             (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) ||
             (c >= CHAR_ZERO && c <= CHAR_NINE) ||
             c == CHAR_DASH || c == CHAR_USCORE;
   endfunction

   // character to sextet, zero for characters outside the alphabet
   function automatic logic [5:0] dec_char(input logic [7:0] c, input logic alt);
      logic [7:0] r;
      r = 8'd0;
      if (!alt) begin
         if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z)      r = c - CHAR_UPPER_A;
         else if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) r = c - CHAR_LOWER_A + 8'd26;
         else if (c >= CHAR_ZERO && c <= CHAR_NINE)       r = c - CHAR_ZERO + 8'd52;
         else if (c == CHAR_DASH)                         r = 8'd62;
         else if (c == CHAR_USCORE)                       r = 8'd63;
      end else begin
         if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z)      r = c - CHAR_LOWER_A;
         else if (c >= CHAR_ZERO && c <= CHAR_NINE)       r = c - CHAR_ZERO + 8'd26;
         else if (c == CHAR_DASH)                         r = 8'd36;
         else if (c == CHAR_USCORE)                       r = 8'd37;
         else if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) r = c - CHAR_UPPER_A + 8'd38;
      end
      return r[5:0];
   endfunction

endpackage

### hw/rtl/base64url_stream_codec.sv
// base64url_stream_codec: top level, unpadded base64url coder over bytes.
// Depends on b64sc_pkg, b64sc_front, b64sc_queue and b64sc_back.
//
// Usage:
//  - req channel carries one byte (raw byte when encoding, character when
//    decoding) with in_last marking the end of the message.
//  - rsp channel carries result words: a character or decoded byte, out_last
//    on the final word of a message, no_byte on an empty end marker and
//    input_stopped once decoding met '=' or a bad character.
//  - csr port writes direction (index 0, clears gathering state) and the
//    alphabet (index 1); write only while the block is idle.
// Timing:
//  - an accepted word is turned into a result group in the same cycle and
//    queued; its first result word is offered once the group is at the head.
//  - the front takes one word per cycle while the queue has room; the back
//    gives one result word per cycle while rsp_stall is low, so a group of n
//    words holds the head until all are taken (four chars per three bytes).
//  - req_stall rises only when the queue of QUEUE_DEPTH groups is full.
// Reset (synchronous) selects encode with the standard alphabet and clears
// all state and the queue. A stall on rsp holds the result word steady while
// the front keeps filling the queue.
module base64url_stream_codec #(
   parameter int QUEUE_DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [b64sc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [b64sc_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  b64sc_pkg::req_type                req_data,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output b64sc_pkg::rsp_type                rsp_data
);

   logic               q_full;
   logic               q_not_empty;
   logic               push;
   logic               pop;
   b64sc_pkg::job_type push_job;
   b64sc_pkg::job_type head;

   // front: accept and classify
   b64sc_front u_front (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .q_full      (q_full),
      .push        (push),
      .job         (push_job)
   );

   // group queue
   b64sc_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_job  (push_job),
      .pop       (pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head      (head)
   );

   // back: result words
   b64sc_back u_back (
      .clock     (clock),
      .reset     (reset),
      .not_empty (q_not_empty),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

### hw/rtl/b64sc_front.sv
// b64sc_front: accepts input words, holds configuration and gathering state,
// and turns each word into a result group. Depends on b64sc_pkg.
module b64sc_front (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              csr_wr_en,
   input  logic [b64sc_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [b64sc_pkg::CSR_DATA_W-1:0]  csr_wr_data,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  b64sc_pkg::req_type                req_data,
   input  logic                              q_full,
   output logic                              push,
   output b64sc_pkg::job_type                job
);

   logic        dir_ff, dir_in;
   logic        alt_ff, alt_in;
   logic [23:0] held_bits_ff, held_bits_in;
   logic [1:0]  held_count_ff, held_count_in;
   logic        stop_seen_ff, stop_seen_in;

   logic        accept;
   logic        job_valid;
   logic [7:0]  c;
   logic [1:0]  cnt_base;
   logic [1:0]  cnt_new;
   logic [23:0] hb_enc;
   logic [23:0] hb_dec;
   logic [3:0][5:0] sx;

   assign req_stall = q_full;
   assign accept    = req_valid && !req_stall;
   assign c         = req_data.in_byte;
   assign push      = accept && job_valid;

   // next state and result group
   always_comb begin
      dir_in        = dir_ff;
      alt_in        = alt_ff;
      held_bits_in  = held_bits_ff;
      held_count_in = held_count_ff;
      stop_seen_in  = stop_seen_ff;
      job_valid     = 1'b0;
      job           = '0;
      sx            = '0;
      cnt_base      = (held_count_ff == 2'd3) ? 2'd0 : held_count_ff;
      cnt_new       = cnt_base + 2'd1;
      hb_enc        = {held_bits_ff[15:0], c};
      hb_dec        = {held_bits_ff[17:0], b64sc_pkg::dec_char(c, alt_ff)};

      if (dir_ff == b64sc_pkg::DIR_ENCODE) begin
         // encode: three bytes make four characters
         if (cnt_new == 2'd3) begin
            sx            = {hb_enc[5:0], hb_enc[11:6], hb_enc[17:12], hb_enc[23:18]};
            job.cnt_m1    = 2'd3;
            job_valid     = 1'b1;
            held_bits_in  = '0;
            held_count_in = 2'd0;
         end else begin
            held_bits_in  = hb_enc;
            held_count_in = cnt_new;
            if (req_data.in_last) begin
               job_valid = 1'b1;
               if (cnt_new == 2'd1) begin
                  sx         = {6'd0, 6'd0, {c[1:0], 4'b0000}, c[7:2]};
                  job.cnt_m1 = 2'd1;
               end else begin
                  sx         = {6'd0, {hb_enc[3:0], 2'b00}, hb_enc[9:4], hb_enc[15:10]};
                  job.cnt_m1 = 2'd2;
               end
            end
         end
         for (int i = 0; i < 4; i++) begin
            job.data[i] = b64sc_pkg::enc_char(sx[i], alt_ff);
         end
      end else begin
         // decode: four sextets make three bytes, stop on a bad character
         if (!stop_seen_ff) begin
            if (!b64sc_pkg::is_url_char(c)) begin
               stop_seen_in = 1'b1;
            end else if (held_count_ff == 2'd3) begin
               job.data      = {8'd0, hb_dec[7:0], hb_dec[15:8], hb_dec[23:16]};
               job.cnt_m1    = 2'd2;
               job_valid     = 1'b1;
               held_bits_in  = '0;
               held_count_in = 2'd0;
            end else begin
               held_bits_in  = hb_dec;
               held_count_in = held_count_ff + 2'd1;
            end
         end
         // tail flush or empty end marker
         if (req_data.in_last && !job_valid) begin
            job_valid = 1'b1;
            if (held_count_in == 2'd2) begin
               job.data[0] = held_bits_in[11:4];
               job.cnt_m1  = 2'd0;
            end else if (held_count_in == 2'd3) begin
               job.data[0] = held_bits_in[17:10];
               job.data[1] = held_bits_in[9:2];
               job.cnt_m1  = 2'd1;
            end else begin
               job.nob = 1'b1;
            end
         end
         job.stop = stop_seen_in;
      end
      job.last = req_data.in_last;

      if (!accept) begin
         held_bits_in  = held_bits_ff;
         held_count_in = held_count_ff;
         stop_seen_in  = stop_seen_ff;
      end else if (req_data.in_last) begin
         held_bits_in  = '0;
         held_count_in = 2'd0;
         stop_seen_in  = 1'b0;
      end

      // configuration writes: the user must write only while idle; the block does not enforce it
      if (csr_wr_en) begin
         if (csr_index == b64sc_pkg::CSR_DIRECTION) begin
            dir_in        = csr_wr_data[0];
            held_bits_in  = '0;
            held_count_in = 2'd0;
            stop_seen_in  = 1'b0;
         end else if (csr_index == b64sc_pkg::CSR_ALPHABET) begin
            alt_in = csr_wr_data[0];
         end
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         dir_ff        <= b64sc_pkg::DIR_ENCODE;
         alt_ff        <= 1'b0;
         held_bits_ff  <= '0;
         held_count_ff <= 2'd0;
         stop_seen_ff  <= 1'b0;
      end else begin
         dir_ff        <= dir_in;
         alt_ff        <= alt_in;
         held_bits_ff  <= held_bits_in;
         held_count_ff <= held_count_in;
         stop_seen_ff  <= stop_seen_in;
      end
   end

endmodule

### hw/rtl/b64sc_queue.sv
// b64sc_queue: short fifo of result groups between front and back.
// Depends on b64sc_pkg for the group type.
module b64sc_queue #(
   parameter int DEPTH = b64sc_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  b64sc_pkg::job_type push_job,
   input  logic               pop,
   output logic               full,
   output logic               not_empty,
   output b64sc_pkg::job_type head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   b64sc_pkg::job_type mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   assign full      = (count_ff == CNT_W'(DEPTH));
   assign not_empty = (count_ff != '0);
   assign head      = mem_ff[rd_ptr_ff];

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue count beyond depth");

   a_push_has_room: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_pop_has_data: assert property (@(posedge clock) disable iff (reset)
      pop |-> not_empty)
      else $error("pop from empty queue");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == CNT_W'($past(count_ff) + 1'b1))
      else $error("queue count did not grow on push");

endmodule

### hw/rtl/b64sc_back.sv
// b64sc_back: walks the head group of the queue and hands out one result
// word per cycle while rsp_stall is low. Depends on b64sc_pkg.
module b64sc_back (
   input  logic               clock,
   input  logic               reset,
   input  logic               not_empty,
   input  b64sc_pkg::job_type head,
   output logic               pop,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output b64sc_pkg::rsp_type rsp_data
);

   logic [1:0] idx_ff, idx_in;
   logic       at_end;
   logic       accept;

   assign rsp_valid = not_empty;
   assign accept    = rsp_valid && !rsp_stall;
   assign at_end    = (idx_ff == head.cnt_m1);
   assign pop       = accept && at_end;

   // result word from the head group
   always_comb begin
      rsp_data.out_byte      = head.data[idx_ff];
      rsp_data.out_last      = head.last && at_end;
      rsp_data.no_byte       = head.nob;
      rsp_data.input_stopped = head.stop;
      idx_in = idx_ff;
      if (accept) begin
         idx_in = at_end ? 2'd0 : idx_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff <= 2'd0;
      end else begin
         idx_ff <= idx_in;
      end
   end

endmodule
